>>> rtl/scta_pkg.sv
package scta_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CHAR_W     = 7;
    localparam int CODE_W     = 8;
    localparam int COUNT_W    = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] POLL_RESET = COUNT_W'(100000);

    typedef enum logic [1:0] {
        CMD_IRQ  = 2'd0,
        CMD_HAS  = 2'd1,
        CMD_GET  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Decoded operation handed from the front end to the FIFO engine.
    typedef struct packed {
        logic              push;
        logic [CHAR_W-1:0] ch;
        logic              pop;
    } op_t;

    typedef struct packed {
        logic              has_char;
        logic              char_valid;
        logic [CHAR_W-1:0] char_out;
    } res_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Scan-code set 1 make codes to US-layout ASCII; unmapped codes give zero.
    function automatic logic [CHAR_W-1:0] keymap(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            7'd1:    c = 7'd27;
            7'd2:    c = 7'd49;
            7'd3:    c = 7'd50;
            7'd4:    c = 7'd51;
            7'd5:    c = 7'd52;
            7'd6:    c = 7'd53;
            7'd7:    c = 7'd54;
            7'd8:    c = 7'd55;
            7'd9:    c = 7'd56;
            7'd10:   c = 7'd57;
            7'd11:   c = 7'd48;
            7'd12:   c = 7'd45;
            7'd13:   c = 7'd61;
            7'd14:   c = 7'd8;
            7'd15:   c = 7'd9;
            7'd16:   c = 7'd113;
            7'd17:   c = 7'd119;
            7'd18:   c = 7'd101;
            7'd19:   c = 7'd114;
            7'd20:   c = 7'd116;
            7'd21:   c = 7'd121;
            7'd22:   c = 7'd117;
            7'd23:   c = 7'd105;
            7'd24:   c = 7'd111;
            7'd25:   c = 7'd112;
            7'd26:   c = 7'd91;
            7'd27:   c = 7'd93;
            7'd28:   c = 7'd10;
            7'd30:   c = 7'd97;
            7'd31:   c = 7'd115;
            7'd32:   c = 7'd100;
            7'd33:   c = 7'd102;
            7'd34:   c = 7'd103;
            7'd35:   c = 7'd104;
            7'd36:   c = 7'd106;
            7'd37:   c = 7'd107;
            7'd38:   c = 7'd108;
            7'd39:   c = 7'd59;
            7'd40:   c = 7'd39;
            7'd41:   c = 7'd96;
            7'd43:   c = 7'd92;
            7'd44:   c = 7'd122;
            7'd45:   c = 7'd120;
            7'd46:   c = 7'd99;
            7'd47:   c = 7'd118;
            7'd48:   c = 7'd98;
            7'd49:   c = 7'd110;
            7'd50:   c = 7'd109;
            7'd51:   c = 7'd44;
            7'd52:   c = 7'd46;
            7'd53:   c = 7'd47;
            7'd55:   c = 7'd42;
            7'd57:   c = 7'd32;
            7'd74:   c = 7'd45;
            7'd78:   c = 7'd43;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/scancode_to_ascii_fifo.sv
// An accepted transaction is written into the queue, taken by the FIFO engine when it is
// idle, and registered in the output register; a popping get-char first passes B_READ, B_DATA.
// Throughput: one transaction per cycle while the queue has room; a popping get-char holds
// the FIFO engine in B_READ and B_DATA because of the store RAM's registered read.
// Reset (rst_n, asynchronous, active low) clears the pointers, the poll counter and the
// queue and loads the poll interval with 100000; the character store is not cleared.
module scancode_to_ascii_fifo (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: poll check period, 20 bits.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] scancode, [8] status_ready, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [6:0] char_out, [7] char_valid, [8] has_char, [15:9] 0
);
    import scta_pkg::*;

    // The front end handles the poll divider and turns each transaction into a decoded
    // push/pop operation. A short queue decouples it from the FIFO engine, so the
    // input side keeps accepting transactions until the queue is full while the engine waits
    // on the RAM or on the output register.
    logic q_in_valid;
    logic q_in_ready;
    op_t  q_in_op;
    logic q_out_valid;
    logic q_out_ready;
    op_t  q_out_op;
    res_t res;

    scta_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .cmd         (cmd_t'(s_tuser)),
        .scancode    (s_tdata[7:0]),
        .status_ready(s_tdata[8]),
        .op_valid    (q_in_valid),
        .op_ready    (q_in_ready),
        .op          (q_in_op)
    );

    scta_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_valid(q_in_valid),
        .wr_ready(q_in_ready),
        .wr_op   (q_in_op),
        .rd_valid(q_out_valid),
        .rd_ready(q_out_ready),
        .rd_op   (q_out_op)
    );

    // The engine owns the ring pointers, the character store and the output register.
    scta_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_out_valid),
        .op_ready (q_out_ready),
        .op       (q_out_op),
        .res_valid(m_tvalid),
        .res_ready(m_tready),
        .res      (res)
    );

    assign m_tdata = {7'b0, res.has_char, res.char_valid, res.char_out};

`ifndef SYNTHESIS
    // A result without a popped character carries a zero character.
    a_char_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[7] |-> m_tdata[6:0] == 7'd0)
        else $error("char_out nonzero without char_valid");

    // Zero codes are never pushed, so a popped character is never zero.
    a_popped_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7] |-> m_tdata[6:0] != 7'd0)
        else $error("popped a zero character");

    // A pop always leaves the FIFO consistent: popping implies the FIFO was nonempty, so
    // a popped character right after an accepted result without has_char needs pending input.
    a_pop_needs_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tdata[8] |=> !(m_tvalid && m_tdata[7]) || $past(s_tvalid)
            || $past(q_out_valid))
        else $error("character popped from an empty FIFO");
`endif

endmodule

>>> rtl/scta_ram.sv
module scta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/scta_front.sv
module scta_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [scta_pkg::COUNT_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  scta_pkg::cmd_t               cmd,
    input  logic [scta_pkg::CODE_W-1:0]  scancode,
    input  logic                         status_ready,
    output logic                         op_valid,
    input  logic                         op_ready,
    output scta_pkg::op_t                op
);
    import scta_pkg::*;

    logic [COUNT_W-1:0] check_period_reg;
    logic [COUNT_W-1:0] poll_count_reg;
    logic [COUNT_W-1:0] poll_count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               is_poll;
    logic               check;
    logic               handle;
    logic [CHAR_W-1:0]  ch;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = op_ready;
    assign op_valid  = in_valid;
    assign accept    = in_valid && op_ready;

    assign is_poll   = (cmd == CMD_HAS) || (cmd == CMD_GET);
    assign count_inc = poll_count_reg + 1'b1;
    assign check     = is_poll && (count_inc >= check_period_reg);
    assign handle    = (cmd == CMD_IRQ) || (check && status_ready);
    assign ch        = keymap(scancode[CHAR_W-1:0]);

    always_comb
    begin
        poll_count_next = poll_count_reg;
        if (accept && is_poll)
        begin
            poll_count_next = check ? '0 : count_inc;
        end
    end

    always_comb
    begin
        op.push = handle && !scancode[CODE_W-1] && (ch != '0);
        op.ch   = ch;
        op.pop  = (cmd == CMD_GET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_period_reg <= POLL_RESET;
            poll_count_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                check_period_reg <= cfg_data;
            end
            poll_count_reg <= poll_count_next;
        end
    end

endmodule

>>> rtl/scta_queue.sv
module scta_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  scta_pkg::op_t wr_op,
    output logic          rd_valid,
    input  logic          rd_ready,
    output scta_pkg::op_t rd_op
);
    import scta_pkg::*;

    op_t                entry_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0]  wr_idx_reg;
    logic [QIDX_W-1:0]  rd_idx_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_op    = entry_reg[rd_idx_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_idx_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_idx_reg <= (wr_idx_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_idx_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_idx_reg <= (rd_idx_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_idx_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/scta_back.sv
module scta_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_ready,
    input  scta_pkg::op_t  op,
    output logic           res_valid,
    input  logic           res_ready,
    output scta_pkg::res_t res
);
    import scta_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_DATA
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [PTR_W-1:0]   rp_reg;
    logic [PTR_W-1:0]   rp_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    res_t               res_reg;
    res_t               res_next;
    logic               slot_free;
    logic               take;
    logic               ram_we;
    logic [PTR_W-1:0]   wp_inc;
    logic [PTR_W-1:0]   rp_inc;
    logic [CHAR_W-1:0]  rdata;

    scta_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(FIFO_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wp_reg),
        .wdata(op.ch),
        .raddr(rp_reg),
        .rdata(rdata)
    );

    assign slot_free = !res_valid_reg || res_ready;
    assign op_ready  = (state_reg == B_IDLE) && slot_free;
    assign take      = op_valid && op_ready;
    assign wp_inc    = ptr_inc(wp_reg);
    assign rp_inc    = ptr_inc(rp_reg);
    assign ram_we    = take && op.push && (wp_inc != rp_reg);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    if (ram_we)
                    begin
                        wp_next = wp_inc;
                    end
                    if (op.pop && (wp_next != rp_reg))
                    begin
                        // The pop reads the store once the push write has settled.
                        state_next = B_READ;
                    end
                    else
                    begin
                        res_valid_next      = 1'b1;
                        res_next.char_out   = '0;
                        res_next.char_valid = 1'b0;
                        res_next.has_char   = (wp_next != rp_reg);
                    end
                end
            end
            B_READ:
            begin
                state_next = B_DATA;
            end
            B_DATA:
            begin
                if (slot_free)
                begin
                    state_next          = B_IDLE;
                    rp_next             = rp_inc;
                    res_valid_next      = 1'b1;
                    res_next.char_out   = rdata;
                    res_next.char_valid = 1'b1;
                    res_next.has_char   = (wp_reg != rp_inc);
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
